// ===== design/rhcb_pkg.sv =====
// Shared types and constants for the rolling hash chunk boundary finder.
package rhcb_pkg;

  // Only the low bits of the rolling hash reach the cut compare
  localparam int unsigned HASH_W = 31;
  localparam int unsigned VAL_W  = 9;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 24;
  localparam int unsigned RUN_W  = 25;
  localparam int unsigned CFG_DW = 64;
  localparam int unsigned CFG_AW = 3;

  // Register reset values
  localparam logic [HASH_W-1:0] MULT_RESET = HASH_W'(3);
  localparam logic [63:0]       PPW_RESET  = 64'd2721702152408675777;
  localparam logic [HASH_W-1:0] MASK_RESET = HASH_W'(65535);
  localparam logic [LEN_W-1:0]  MIN_RESET  = LEN_W'(32768);
  localparam logic [LEN_W-1:0]  MAX_RESET  = LEN_W'(262144);

  // Configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    CFG_MULT = 3'd0,
    CFG_PPW  = 3'd1,
    CFG_MASK = 3'd2,
    CFG_MIN  = 3'd3,
    CFG_MAX  = 3'd4
  } cfg_idx_e;

  // Item kinds
  localparam logic REQ_DATA  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef struct packed {
    logic [HASH_W-1:0] mult;
    logic [HASH_W-1:0] ppw;
    logic [HASH_W-1:0] mask;
    logic [LEN_W-1:0]  min_len;
    logic [LEN_W-1:0]  max_len;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [RUN_W-1:0] length;
    logic             final_flag;
  } result_t;

endpackage

// ===== design/rolling_hash_chunk_boundary.sv =====
// Top level of the content-defined chunk boundary finder.
// Takes one item per clock cycle while the skid entry is empty: each data byte rolls a
// polynomial hash over a window of the last WINDOW bytes, held in a row of cells that shift
// once per byte, and, once the chunk passes min_length, a boundary is reported when the
// masked hash equals one or the chunk passes max_length. An end-of-stream item reports the
// remaining length and clears the hash, window and length. A result is registered in an
// output register backed by one skid entry, so input stalls only when both are full. The
// throughput of one byte per cycle is set by the loop through the hash register, one 31 x 31
// multiply-add each cycle; only the low 31 hash bits are kept since the cut mask is 31 bits.
// The user writes configuration through cfg_we_i / cfg_idx_i / cfg_wdata_i only while no item
// is in flight; the block does not enforce it. prime_pow_window acts through its low 31 bits.
module rolling_hash_chunk_boundary
  import rhcb_pkg::*;
#(
  parameter int unsigned WINDOW = 48
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_type_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [RUN_W-1:0]  chunk_length_o,
  output logic              is_final_o
);

  cfg_t             cfg_q;
  cfg_t             cfg_d;
  logic             accept;
  logic [VAL_W-1:0] value;
  logic [VAL_W-1:0] chain [WINDOW+1];
  result_t          res;
  result_t          out_q;
  result_t          out_d;
  result_t          skid_q;
  result_t          skid_d;

  // Configuration writes; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MULT: cfg_d.mult    = cfg_wdata_i[HASH_W-1:0];
        CFG_PPW:  cfg_d.ppw     = cfg_wdata_i[HASH_W-1:0];
        CFG_MASK: cfg_d.mask    = cfg_wdata_i[HASH_W-1:0];
        CFG_MIN:  cfg_d.min_len = cfg_wdata_i[LEN_W-1:0];
        CFG_MAX:  cfg_d.max_len = cfg_wdata_i[LEN_W-1:0];
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mult    <= MULT_RESET;
      cfg_q.ppw     <= PPW_RESET[HASH_W-1:0];
      cfg_q.mask    <= MASK_RESET;
      cfg_q.min_len <= MIN_RESET;
      cfg_q.max_len <= MAX_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_ready_o = !skid_q.valid;
  assign accept     = in_valid_i && in_ready_o;
  assign value      = VAL_W'(data_byte_i) + VAL_W'(1);

  // Window: the newest value enters cell 0, the oldest leaves the last cell
  assign chain[0] = value;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    rhcb_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (accept && (req_type_i == REQ_DATA)),
      .clear_i (accept && (req_type_i == REQ_FLUSH)),
      .d_i     (chain[i]),
      .q_o     (chain[i+1])
    );
  end

  rhcb_roll u_roll (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_type_i (req_type_i),
    .value_i    (value),
    .oldest_i   (chain[WINDOW]),
    .cfg_i      (cfg_q),
    .res_o      (res)
  );

  // Output register with one skid entry; refill from skid first
  always_comb begin
    out_d  = out_q;
    skid_d = skid_q;
    if (!out_q.valid || out_ready_i) begin
      if (skid_q.valid) begin
        out_d        = skid_q;
        skid_d.valid = 1'b0;
      end else begin
        out_d = res;
      end
    end else if (res.valid) begin
      skid_d = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q  <= '0;
      skid_q <= '0;
    end else begin
      out_q  <= out_d;
      skid_q <= skid_d;
    end
  end

  assign out_valid_o    = out_q.valid;
  assign chunk_length_o = out_q.length;
  assign is_final_o     = out_q.final_flag;

endmodule

// ===== design/rhcb_cell.sv =====
// One window cell: holds a byte value and hands it to the next cell on each data item.
module rhcb_cell
  import rhcb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic             clear_i,
  input  logic [VAL_W-1:0] d_i,
  output logic [VAL_W-1:0] q_o
);

  logic [VAL_W-1:0] val_q;
  logic [VAL_W-1:0] val_d;

  // Clear on end of stream, take the neighbor's value on a data item
  always_comb begin
    val_d = val_q;
    if (clear_i) begin
      val_d = '0;
    end else if (shift_i) begin
      val_d = d_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

  assign q_o = val_q;

endmodule

// ===== design/rhcb_roll.sv =====
// Rolling hash update, running length and cut decision for each accepted item.
module rhcb_roll
  import rhcb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             req_type_i,
  input  logic [VAL_W-1:0] value_i,
  input  logic [VAL_W-1:0] oldest_i,
  input  cfg_t             cfg_i,
  output result_t          res_o
);

  localparam logic [RUN_W-1:0] RUN_SAT = '1;

  logic [HASH_W-1:0] hash_q;
  logic [HASH_W-1:0] hash_d;
  logic [RUN_W-1:0]  run_q;
  logic [RUN_W-1:0]  run_d;
  logic [HASH_W-1:0] mul_hash;
  logic [HASH_W-1:0] mul_old;
  logic [HASH_W-1:0] hash_new;
  logic              long_enough;
  logic              cut;

  // Multiply-add, wrapping; carries only move upward so the low bits stand alone
  assign mul_hash = HASH_W'(hash_q * cfg_i.mult);
  assign mul_old  = HASH_W'(oldest_i * cfg_i.ppw);
  assign hash_new = mul_hash + HASH_W'(value_i) - mul_old;

  assign long_enough = run_q > RUN_W'(cfg_i.min_len);
  assign cut = long_enough &&
               (((hash_new & cfg_i.mask) == HASH_W'(1)) || (run_q > RUN_W'(cfg_i.max_len)));

  // Advance hash and length, emit a result on a cut or a flush
  always_comb begin
    hash_d           = hash_q;
    run_d            = run_q;
    res_o.valid      = 1'b0;
    res_o.length     = run_q;
    res_o.final_flag = 1'b0;
    if (accept_i) begin
      if (req_type_i == REQ_FLUSH) begin
        hash_d           = '0;
        run_d            = '0;
        res_o.valid      = 1'b1;
        res_o.final_flag = 1'b1;
      end else begin
        hash_d = hash_new;
        if (cut) begin
          res_o.valid = 1'b1;
          run_d       = RUN_W'(1);
        end else if (run_q != RUN_SAT) begin
          run_d = run_q + RUN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
      run_q  <= '0;
    end else begin
      hash_q <= hash_d;
      run_q  <= run_d;
    end
  end

endmodule

// ===== design/rhcb_chk.sv =====
// Port-level checks for the chunk boundary finder, bound to the top level.
module rhcb_chk
  import rhcb_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              req_type_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [RUN_W-1:0]  chunk_length_o,
  input logic              is_final_o
);

  // Hold a stalled result
  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !out_ready_i |=> out_valid_o && $stable(chunk_length_o)
                                      && $stable(is_final_o);
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("stalled result changed");

  // Input stalls only with a result waiting at the output
  property p_stall_needs_result;
    @(posedge clk_i) disable iff (!rst_ni)
      !in_ready_o |-> out_valid_o;
  endproperty
  a_stall_needs_result: assert property (p_stall_needs_result)
    else $error("input stalled with empty output");

  // A flush taken into a free output shows up next cycle as a final item
  property p_flush_out;
    @(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && in_ready_o && (req_type_i == REQ_FLUSH) && (!out_valid_o || out_ready_i)
        |=> out_valid_o && is_final_o;
  endproperty
  a_flush_out: assert property (p_flush_out) else $error("flush result missing");

  // A boundary inside the stream always closes a non-empty chunk
  property p_cut_nonempty;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !is_final_o |-> chunk_length_o != '0;
  endproperty
  a_cut_nonempty: assert property (p_cut_nonempty) else $error("empty chunk at a cut");

endmodule

bind rolling_hash_chunk_boundary rhcb_chk u_rhcb_chk (.*);

// ===== test/chunk_length_checker.sv =====
// Checker for the chunk boundary finder: tracks registers, predicts chunk results, compares.
`timescale 1ns / 100ps
module chunk_length_checker
  import rhcb_pkg::*;
#(
  parameter int unsigned WINDOW = 48
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              req_type_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [RUN_W-1:0]  chunk_length_i,
  input  logic              is_final_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                chunks_seen_o
);

  typedef struct packed {
    logic [RUN_W-1:0] length;
    logic             final_flag;
  } chunk_t;

  // Register copies
  logic [HASH_W-1:0] mult_q;
  logic [63:0]       ppw_q;
  logic [HASH_W-1:0] mask_q;
  logic [LEN_W-1:0]  min_q;
  logic [LEN_W-1:0]  max_q;

  // Rolling state
  logic [63:0]      hash_q;
  logic [VAL_W-1:0] window_q [WINDOW];
  int unsigned      slot_q;
  logic [RUN_W-1:0] run_q;

  chunk_t expected_chunks [$];

  function automatic void clear_chunk_state();
    hash_q = '0;
    foreach (window_q[i]) window_q[i] = '0;
    slot_q = 0;
    run_q  = '0;
  endfunction

  function automatic void reset_regs();
    mult_q = MULT_RESET;
    ppw_q  = PPW_RESET;
    mask_q = MASK_RESET;
    min_q  = MIN_RESET;
    max_q  = MAX_RESET;
  endfunction

  // Mirror a register write; unknown indexes are dropped
  function automatic void apply_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
    case (idx)
      CFG_MULT: mult_q = data[HASH_W-1:0];
      CFG_PPW:  ppw_q  = data[63:0];
      CFG_MASK: mask_q = data[HASH_W-1:0];
      CFG_MIN:  min_q  = data[LEN_W-1:0];
      CFG_MAX:  max_q  = data[LEN_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the chunker by one item; return 1 when it closes a chunk
  function automatic bit roll_item(logic req, logic [BYTE_W-1:0] b, output chunk_t c);
    logic [VAL_W-1:0] v;
    bit               emit;
    emit = 1'b0;
    c    = '0;
    if (req == REQ_FLUSH) begin
      c.length     = run_q;
      c.final_flag = 1'b1;
      clear_chunk_state();
      return 1'b1;
    end
    v = VAL_W'(b) + 1'b1;
    hash_q = hash_q * 64'(mult_q) + 64'(v) - 64'(window_q[slot_q]) * ppw_q;
    window_q[slot_q] = v;
    slot_q = (slot_q == WINDOW - 1) ? 0 : slot_q + 1;
    // Cut on hash match or length limit, but only past the minimum
    if (run_q > RUN_W'(min_q)) begin
      if ((hash_q & 64'(mask_q)) == 64'd1 || run_q > RUN_W'(max_q)) begin
        c.length = run_q;
        emit     = 1'b1;
        run_q    = '0;
      end
    end
    if (run_q != '1) run_q = run_q + 1'b1;
    return emit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    chunk_t got;
    chunk_t want;
    chunk_t next_chunk;
    if (!rst_ni) begin
      reset_regs();
      clear_chunk_state();
      expected_chunks.delete();
      fail_count_o  = 0;
      chunks_seen_o = 0;
    end else begin
      // Compare a delivered item against the oldest expectation
      if (out_valid_i && out_ready_i) begin
        got.length     = chunk_length_i;
        got.final_flag = is_final_i;
        chunks_seen_o++;
        if (expected_chunks.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected chunk: length %0d final %0b", $time,
                   got.length, got.final_flag);
        end else begin
          want = expected_chunks.pop_front();
          if (got.length !== want.length) begin
            fail_count_o++;
            $display("%0t: chunk_length expected %0d, got %0d", $time,
                     want.length, got.length);
          end
          if (got.final_flag !== want.final_flag) begin
            fail_count_o++;
            $display("%0t: is_final expected %0b, got %0b", $time,
                     want.final_flag, got.final_flag);
          end
        end
      end
      // Predict from an accepted input item
      if (in_valid_i && in_ready_i) begin
        if (roll_item(req_type_i, data_byte_i, next_chunk))
          expected_chunks.push_back(next_chunk);
      end
      if (cfg_we_i) apply_reg(cfg_idx_i, cfg_wdata_i);
    end
    pending_o = expected_chunks.size();
  end

endmodule

// ===== test/tb_rolling_hash_chunk_boundary.sv =====
// Testbench top for the chunk boundary finder: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_rolling_hash_chunk_boundary;
  import rhcb_pkg::*;

  localparam int unsigned WIN           = 48;
  localparam int          NUM_SETTINGS  = 9;
  localparam int          DRAIN_LIMIT   = 5000;
  localparam int          SETTLE_CYCLES = 4;
  localparam logic [CFG_AW-1:0] CFG_SPARE_LO = CFG_AW'(CFG_MAX) + 1'b1;
  localparam logic [CFG_AW-1:0] CFG_SPARE_HI = '1;
  localparam logic [HASH_W-1:0] ALL_ONES31   = '1;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [CFG_AW-1:0] cfg_idx_i   = CFG_MULT;
  logic [CFG_DW-1:0] cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic              req_type_i  = REQ_DATA;
  logic [BYTE_W-1:0] data_byte_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [RUN_W-1:0]  chunk_length_o;
  logic              is_final_o;

  int fail_count;
  int pending;
  int chunks_seen;
  int items_sent      = 0;
  int settings_loaded = 0;
  bit steady          = 1'b0;
  int stall_left      = 0;
  int calm_left       = 0;

  logic [BYTE_W-1:0] probe_bytes [11] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE,
                                          8'hAA, 8'h55, 8'hFF, 8'hFF, 8'h00};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rolling_hash_chunk_boundary #(.WINDOW(WIN)) uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .req_type_i, .data_byte_i,
    .out_valid_o, .out_ready_i, .chunk_length_o, .is_final_o
  );

  chunk_length_checker #(.WINDOW(WIN)) u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .req_type_i, .data_byte_i,
    .out_valid_i(out_valid_o), .out_ready_i, .chunk_length_i(chunk_length_o),
    .is_final_i(is_final_o),
    .fail_count_o(fail_count), .pending_o(pending), .chunks_seen_o(chunks_seen)
  );

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // Receiver: ready stretches, short stalls and the odd long stall
  always @(negedge clk_i) begin : ready_gen
    int r;
    if (calm_left > 0) begin
      out_ready_i <= 1'b1;
      calm_left--;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      r = $urandom_range(0, 99);
      if (r < 3) calm_left = $urandom_range(50, 200);
      else if (r < 28) stall_left = $urandom_range(1, 3);
      else if (r < 31) stall_left = $urandom_range(10, 40);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Multiplier raised to the window length, mod 2^64
  function automatic logic [63:0] window_power(logic [HASH_W-1:0] base);
    logic [63:0] acc;
    acc = 64'd1;
    repeat (WIN) acc = acc * 64'(base);
    return acc;
  endfunction

  // Fill the bits above a register's width with noise
  function automatic logic [CFG_DW-1:0] stuff_upper(logic [CFG_DW-1:0] val, int unsigned w);
    logic [CFG_DW-1:0] noise;
    noise = {$urandom, $urandom};
    if (w >= CFG_DW) return val;
    return (noise << w) | val;
  endfunction

  // Called at a falling edge; returns at a falling edge after the item and its gap
  task automatic send_item(input logic req, input logic [BYTE_W-1:0] b);
    int gap;
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    data_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Hold off input until every expected item has come back, then let the pipe empty
  task automatic drain_results();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (pending > 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Write all registers, then poke the unused indexes, which must change nothing
  task automatic load_setting(input logic [HASH_W-1:0] mult, input logic [63:0] ppw,
                              input logic [HASH_W-1:0] mask, input logic [LEN_W-1:0] min_len,
                              input logic [LEN_W-1:0] max_len);
    write_reg(CFG_MULT, stuff_upper(CFG_DW'(mult), HASH_W));
    write_reg(CFG_PPW, ppw);
    write_reg(CFG_MASK, stuff_upper(CFG_DW'(mask), HASH_W));
    write_reg(CFG_MIN, stuff_upper(CFG_DW'(min_len), LEN_W));
    write_reg(CFG_MAX, stuff_upper(CFG_DW'(max_len), LEN_W));
    for (int k = CFG_SPARE_LO; k <= CFG_SPARE_HI; k++)
      write_reg(CFG_AW'(k), {$urandom, $urandom});
    settings_loaded++;
  endtask

  // Random bytes with frequent 00 and FF values and occasional flushes
  task automatic run_phase(input int n_items, input int flush_pct);
    int          r;
    logic        req;
    logic [7:0]  b;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 79) == 0) drain_results();
      req = ($urandom_range(0, 99) < flush_pct) ? REQ_FLUSH : REQ_DATA;
      r = $urandom_range(0, 99);
      b = (r < 10) ? 8'h00 : (r < 20) ? 8'hFF : 8'($urandom);
      send_item(req, b);
    end
  endtask

  initial begin
    logic [HASH_W-1:0] m;
    logic [HASH_W-1:0] mask;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: a short chunk, then an empty one; the flush byte is ignored
    send_item(REQ_DATA, 8'h00);
    send_item(REQ_DATA, 8'hFF);
    send_item(REQ_FLUSH, 8'hFF);
    send_item(REQ_FLUSH, 8'h00);
    drain_results();

    // Tight lengths: cut on odd hash past two bytes, forced cut past five
    load_setting(HASH_W'(3), window_power(HASH_W'(3)), HASH_W'(1), 24'd2, 24'd5);
    foreach (probe_bytes[k]) send_item(REQ_DATA, probe_bytes[k]);
    send_item(REQ_FLUSH, 8'h5A);
    drain_results();

    // Mask of zero never matches: only the length limit cuts
    load_setting(HASH_W'(3), window_power(HASH_W'(3)), '0, 24'd1, 24'd3);
    for (int k = 0; k < 8; k++) send_item(REQ_DATA, probe_bytes[10 - k]);
    send_item(REQ_FLUSH, 8'hA5);

    // Random part over a spread of settings, extremes included
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      drain_results();
      steady = ($urandom_range(0, 3) == 0);
      m = HASH_W'($urandom_range(1, 32'h7FFF_FFFF));
      case (p)
        0: load_setting(HASH_W'(3), window_power(HASH_W'(3)), HASH_W'(7), 24'd4, 24'd40);
        1: load_setting(HASH_W'(1), window_power(HASH_W'(1)), HASH_W'(3), '0, 24'd16);
        2: load_setting(ALL_ONES31, '1, ALL_ONES31, 24'd3, 24'd12);
        3: load_setting(m, '0, '0, 24'd10, '0);
        4: load_setting(m, window_power(m), HASH_W'(1), '0, '0);
        5: load_setting(m, window_power(m), HASH_W'(15), '1, '1);
        default: begin
          if ($urandom_range(0, 99) < 60)
            mask = HASH_W'($urandom) & HASH_W'((1 << $urandom_range(1, 5)) - 1) | 1'b1;
          else
            mask = HASH_W'($urandom) | 1'b1;
          load_setting(m, ($urandom_range(0, 1) == 1) ? window_power(m) : {$urandom, $urandom},
                       mask, LEN_W'($urandom_range(0, 20)), LEN_W'($urandom_range(0, 60)));
        end
      endcase
      run_phase((p == 5) ? 30 : 50, (p == 5) ? 8 : 3);
    end
    send_item(REQ_FLUSH, 8'h00);
    drain_results();

    $display("Sent %0d items across %0d register settings; %0d chunk results checked.",
             items_sent, settings_loaded, chunks_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
